FILE: rtl/core/glw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glw_pkg
// types, codes and constants shared by the go-back-n window bookkeeping
// ----------------------------------------------------------------------------
package glw_pkg;

    localparam logic [7:0] MAX_PAYLOAD = 8'd32;
    localparam logic [4:0] QUEUE_DEPTH = 5'd16;

    // operation codes
    localparam logic [1:0] OP_ENQUEUE = 2'd0;
    localparam logic [1:0] OP_PREPARE = 2'd1;
    localparam logic [1:0] OP_RECEIVE = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_TOO_LONG = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_RANGE    = 2'd3;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] msg_length;
        logic [3:0] rx_seq;
        logic [3:0] rx_preack;
        logic       rx_is_real;
        logic       rx_crc_ok;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  slot;
        logic [3:0]  tx_seq;
        logic [3:0]  tx_preack;
        logic        tx_is_real;
        logic        deliver;
        logic [4:0]  avail_count;
        logic [4:0]  unsent_count;
        logic [4:0]  unconfirmed_count;
        logic [31:0] sent_ok_total;
        logic [31:0] received_ok_total;
    } out_item_t;

    typedef struct packed {
        logic [3:0]  next_tx_seq;
        logic [3:0]  next_preack;
        logic [3:0]  sent_seq_now;
        logic [3:0]  sent_preack_now;
        logic [3:0]  prev_round_preack_in;
        logic [3:0]  prev_round_seq_out;
        logic [3:0]  head_unconfirmed;
        logic [3:0]  head_unsent;
        logic [3:0]  head_free;
        logic [4:0]  count_unsent;
        logic [4:0]  count_unconfirmed;
        logic [4:0]  count_free;
        logic [31:0] total_sent_ok;
        logic [31:0] total_received_ok;
    } win_state_t;

    localparam win_state_t WIN_STATE_RESET = '{
        next_tx_seq:          4'd0,
        next_preack:          4'd0,
        sent_seq_now:         4'd0,
        sent_preack_now:      4'd0,
        prev_round_preack_in: 4'd0,
        prev_round_seq_out:   4'd0,
        head_unconfirmed:     4'd0,
        head_unsent:          4'd0,
        head_free:            4'd0,
        count_unsent:         5'd0,
        count_unconfirmed:    5'd0,
        count_free:           QUEUE_DEPTH,
        total_sent_ok:        32'd0,
        total_received_ok:    32'd0
    };

endpackage

FILE: rtl/core/glw_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glw_step
// next window state and result for one item, all in one combinational pass
// ----------------------------------------------------------------------------
module glw_step
(
    input  glw_pkg::in_item_t   item,
    input  glw_pkg::win_state_t st,
    output glw_pkg::win_state_t st_next,
    output glw_pkg::out_item_t  res
);

    always_comb
    begin
        logic [3:0] diff;
        logic [4:0] mv;
        logic [4:0] room;

        st_next = st;
        res     = '0;
        diff    = 4'd0;
        mv      = 5'd0;
        room    = 5'd0;

        unique case (item.op)
            glw_pkg::OP_ENQUEUE:
            begin
                if (item.msg_length > glw_pkg::MAX_PAYLOAD)
                begin
                    res.status = glw_pkg::ST_TOO_LONG;
                end
                else if (st.count_free == 5'd0)
                begin
                    res.status = glw_pkg::ST_FULL;
                end
                else if (st.count_unsent >= glw_pkg::QUEUE_DEPTH)
                begin
                    res.status = glw_pkg::ST_RANGE;
                end
                else
                begin
                    res.slot             = st.head_free;
                    st_next.head_free    = st.head_free + 4'd1;
                    st_next.count_free   = st.count_free - 5'd1;
                    st_next.count_unsent = st.count_unsent + 5'd1;
                end
            end

            glw_pkg::OP_PREPARE:
            begin
                res.tx_seq              = st.next_tx_seq;
                res.tx_preack           = st.next_preack;
                st_next.sent_seq_now    = st.next_tx_seq;
                st_next.sent_preack_now = st.next_preack;
                st_next.next_tx_seq     = st.next_tx_seq + 4'd1;
                if (st.count_unsent != 5'd0)
                begin
                    res.tx_is_real       = 1'b1;
                    res.slot             = st.head_unsent;
                    st_next.head_unsent  = st.head_unsent + 4'd1;
                    st_next.count_unsent = st.count_unsent - 5'd1;
                    if (st.count_unconfirmed < glw_pkg::QUEUE_DEPTH)
                        st_next.count_unconfirmed = st.count_unconfirmed + 5'd1;
                    else
                        res.status = glw_pkg::ST_RANGE;
                end
            end

            glw_pkg::OP_RECEIVE:
            begin
                if (item.rx_crc_ok)
                begin
                    if (item.rx_seq == st.sent_preack_now)
                    begin
                        st_next.next_preack = st.next_preack + 4'd1;
                        if (item.rx_is_real)
                        begin
                            st_next.total_received_ok = st.total_received_ok + 32'd1;
                            res.deliver               = 1'b1;
                        end
                    end

                    // two consistent rounds confirm the oldest slot
                    if (st.prev_round_seq_out == st.prev_round_preack_in &&
                        (st.prev_round_preack_in + 4'd1) == item.rx_preack)
                    begin
                        if (st.count_unconfirmed == 5'd0 ||
                            st.count_free >= glw_pkg::QUEUE_DEPTH)
                        begin
                            res.status = glw_pkg::ST_RANGE;
                        end
                        else
                        begin
                            st_next.count_unconfirmed = st.count_unconfirmed - 5'd1;
                            st_next.count_free        = st.count_free + 5'd1;
                            st_next.total_sent_ok     = st.total_sent_ok + 32'd1;
                            st_next.head_unconfirmed  = st.head_unconfirmed + 4'd1;
                        end
                    end

                    // go back to the first unconfirmed slot, counts clamped
                    if (item.rx_preack != st.sent_seq_now)
                    begin
                        diff = st.head_unsent - st_next.head_unconfirmed;
                        room = glw_pkg::QUEUE_DEPTH - st.count_unsent;
                        mv   = {1'b0, diff};
                        if (mv > st_next.count_unconfirmed)
                            mv = st_next.count_unconfirmed;
                        if (mv > room)
                            mv = room;
                        if (mv != {1'b0, diff})
                            res.status = glw_pkg::ST_RANGE;
                        st_next.count_unsent      = st.count_unsent + mv;
                        st_next.count_unconfirmed = st_next.count_unconfirmed - mv;
                        st_next.head_unsent       = st_next.head_unconfirmed;
                        st_next.next_tx_seq       = st_next.head_unconfirmed;
                    end

                    st_next.prev_round_preack_in = item.rx_preack;
                    st_next.prev_round_seq_out   = st.sent_seq_now;
                end
            end

            default:
            begin
            end
        endcase

        res.avail_count       = st_next.count_free;
        res.unsent_count      = st_next.count_unsent;
        res.unconfirmed_count = st_next.count_unconfirmed;
        res.sent_ok_total     = st_next.total_sent_ok;
        res.received_ok_total = st_next.total_received_ok;
    end

endmodule

FILE: rtl/core/go_back_n_link_window.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// go_back_n_link_window
// bookkeeping for a 16-slot go-back-n retransmit window: enqueue, prepare
// and receive items update the window and give one result item each
// ----------------------------------------------------------------------------
//  channel  | signals                        | payload
//  ---------+--------------------------------+------------------------------
//  input    | in_valid, in_ready, in_data    | glw_pkg::in_item_t
//  output   | out_valid, out_ready, out_data | glw_pkg::out_item_t
//
// one item per cycle while the output is not stalled; an accepted item reaches
// out_data through the input register, then the window update into the result register
// the window state is updated in the cycle the item moves into the result
// register, so back-to-back items see each other's effects in order
// reset clears the window state and both valid flags at once
// a stalled output holds its item while the input register still takes one
// ----------------------------------------------------------------------------
module go_back_n_link_window
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  glw_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output glw_pkg::out_item_t out_data
);

    glw_pkg::in_item_t   item_reg;
    logic                item_valid_reg;
    glw_pkg::win_state_t state_reg;
    glw_pkg::win_state_t state_next;
    glw_pkg::out_item_t  res_reg;
    glw_pkg::out_item_t  res_next;
    logic                res_valid_reg;
    logic                res_free;
    logic                advance;

    glw_step u_step
    (
        .item    (item_reg),
        .st      (state_reg),
        .st_next (state_next),
        .res     (res_next)
    );

    assign res_free = !res_valid_reg || out_ready;
    assign advance  = item_valid_reg && res_free;
    assign in_ready = !item_valid_reg || res_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
            state_reg      <= glw_pkg::WIN_STATE_RESET;
        end
        else
        begin
            if (in_ready)
                item_valid_reg <= in_valid;
            if (res_free)
                res_valid_reg <= item_valid_reg;
            if (advance)
                state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            item_reg <= in_data;
        if (advance)
            res_reg <= res_next;
    end

    assign out_valid = res_valid_reg;
    assign out_data  = res_reg;

endmodule
